>>> design/psi_pkg.sv
package psi_pkg;

    localparam int POSITION_BITS_DEFAULT = 12;
    localparam int TIMER_BITS_DEFAULT    = 20;

    localparam int PERIOD_BITS    = 20;
    localparam int TARGET_BITS    = 12;
    localparam int OUT_POS_BITS   = 12;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    localparam logic [PERIOD_BITS-1:0] STEP_PERIOD_RESET     = 20'd800;
    localparam logic [PERIOD_BITS-1:0] BLINK_PERIOD_RESET    = 20'd400000;
    localparam logic [PERIOD_BITS-1:0] DEBOUNCE_PERIOD_RESET = 20'd100000;
    localparam logic [TARGET_BITS-1:0] APPROACH_POS_RESET    = 12'd900;
    localparam logic [TARGET_BITS-1:0] CLOSE_POS_RESET       = 12'd1800;

    localparam logic [1:0] LIGHT_DARK = 2'b00;
    localparam logic [1:0] LIGHT_BLUE = 2'b01;
    localparam logic [1:0] LIGHT_RED  = 2'b10;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_MESSAGE    = 2'd1,
        OP_DISCONNECT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        LEVEL_SAFE     = 2'd0,
        LEVEL_APPROACH = 2'd1,
        LEVEL_CLOSE    = 2'd2
    } level_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEP_PERIOD     = 3'd0,
        CFG_BLINK_PERIOD    = 3'd1,
        CFG_DEBOUNCE_PERIOD = 3'd2,
        CFG_APPROACH_POS    = 3'd3,
        CFG_CLOSE_POS       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]              coils;
        logic                    light_blue;
        logic                    light_red;
        logic [OUT_POS_BITS-1:0] motor_position;
        logic [1:0]              proximity;
        logic                    paused;
    } result_t;

    function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
        logic [3:0] coils;
        case (phase)
            3'd0: coils = 4'h1;
            3'd1: coils = 4'h3;
            3'd2: coils = 4'h2;
            3'd3: coils = 4'h6;
            3'd4: coils = 4'h4;
            3'd5: coils = 4'hC;
            3'd6: coils = 4'h8;
            3'd7: coils = 4'h9;
            default: coils = 4'h0;
        endcase
        return coils;
    endfunction

endpackage

>>> design/psi_skid.sv
module psi_skid
    import psi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    hold_valid_reg, hold_valid_next;
    result_t hold_data_reg, hold_data_next;
    logic    push;

    assign in_ready  = !hold_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (!out_valid_reg || out_ready) begin
            out_valid_next  = hold_valid_reg || push;
            out_data_next   = hold_valid_reg ? hold_data_reg : in_data;
            hold_valid_next = 1'b0;
        end else if (push) begin
            // park the word while the output is stalled
            hold_valid_next = 1'b1;
            hold_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

endmodule

>>> design/psi_core.sv
module psi_core
    import psi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int TIMER_BITS    = TIMER_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_write_enable,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      accept,
    input  logic [1:0]                op,
    input  logic [1:0]                message_state,
    input  logic                      button_low,
    output result_t                   result
);

    localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POSITION_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    logic [PERIOD_BITS-1:0] step_period_reg, blink_period_reg, debounce_period_reg;
    logic [TARGET_BITS-1:0] approach_pos_reg, close_pos_reg;

    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [2:0]               phase_reg, phase_next;
    level_t                   level_reg, level_next;
    logic                     pause_reg, pause_next;
    logic                     blink_reg, blink_next;
    logic [3:0]               coil_reg, coil_next;
    logic [1:0]               light_reg, light_next;
    logic [TIMER_BITS-1:0]    step_elapsed_reg, step_elapsed_next;
    logic [TIMER_BITS-1:0]    blink_elapsed_reg, blink_elapsed_next;
    logic [TIMER_BITS-1:0]    press_elapsed_reg, press_elapsed_next;

    logic [POSITION_BITS-1:0] approach_target, close_target;

    assign approach_target = POSITION_BITS'(approach_pos_reg);
    assign close_target    = POSITION_BITS'(close_pos_reg);

    always_comb begin
        logic [TIMER_BITS-1:0]    step_inc, blink_inc, press_inc;
        logic                     up;
        level_t                   msg_level;
        step_inc = (step_elapsed_reg == TIMER_MAX) ? TIMER_MAX
                 : step_elapsed_reg + {{(TIMER_BITS-1){1'b0}}, 1'b1};
        blink_inc = (blink_elapsed_reg == TIMER_MAX) ? TIMER_MAX
                  : blink_elapsed_reg + {{(TIMER_BITS-1){1'b0}}, 1'b1};
        press_inc = (press_elapsed_reg == TIMER_MAX) ? TIMER_MAX
                  : press_elapsed_reg + {{(TIMER_BITS-1){1'b0}}, 1'b1};
        up        = target_reg > position_reg;
        msg_level = level_t'(message_state);

        position_next      = position_reg;
        target_next        = target_reg;
        phase_next         = phase_reg;
        level_next         = level_reg;
        pause_next         = pause_reg;
        blink_next         = blink_reg;
        coil_next          = coil_reg;
        light_next         = light_reg;
        step_elapsed_next  = step_elapsed_reg;
        blink_elapsed_next = blink_elapsed_reg;
        press_elapsed_next = press_elapsed_reg;

        case (op_t'(op))
            OP_TICK: begin
                step_elapsed_next  = step_inc;
                blink_elapsed_next = blink_inc;
                press_elapsed_next = press_inc;
                if (CMP_BITS'(step_inc) >= CMP_BITS'(step_period_reg)) begin
                    step_elapsed_next = '0;
                    if (position_reg != target_reg) begin
                        phase_next    = up ? phase_reg - 3'd1 : phase_reg + 3'd1;
                        position_next = up ? position_reg + POSITION_ONE
                                           : position_reg - POSITION_ONE;
                        coil_next     = (position_next == target_reg) ? 4'h0
                                      : half_step_coils(phase_next);
                    end
                end
                if (level_reg == LEVEL_APPROACH && !pause_reg &&
                    CMP_BITS'(blink_inc) >= CMP_BITS'(blink_period_reg)) begin
                    blink_elapsed_next = '0;
                    blink_next         = !blink_reg;
                    light_next         = blink_next ? LIGHT_RED : LIGHT_DARK;
                end
                if (button_low && CMP_BITS'(press_inc) > CMP_BITS'(debounce_period_reg)) begin
                    press_elapsed_next = '0;
                    pause_next         = !pause_reg;
                    if (pause_next) begin
                        light_next  = LIGHT_BLUE;
                        target_next = '0;
                    end else begin
                        case (level_reg)
                            LEVEL_SAFE: begin
                                light_next  = LIGHT_BLUE;
                                target_next = '0;
                            end
                            LEVEL_APPROACH: begin
                                target_next = approach_target;
                            end
                            LEVEL_CLOSE: begin
                                light_next  = LIGHT_RED;
                                target_next = close_target;
                            end
                            default: begin
                                target_next = '0;
                            end
                        endcase
                    end
                end
            end
            OP_MESSAGE: begin
                if (message_state <= 2'(LEVEL_CLOSE)) begin
                    if (pause_reg) begin
                        level_next = msg_level;
                    end else if (msg_level != level_reg) begin
                        level_next = msg_level;
                        case (msg_level)
                            LEVEL_SAFE: begin
                                light_next  = LIGHT_BLUE;
                                target_next = '0;
                            end
                            LEVEL_APPROACH: begin
                                target_next = approach_target;
                            end
                            LEVEL_CLOSE: begin
                                light_next  = LIGHT_RED;
                                target_next = close_target;
                            end
                            default: begin
                                target_next = '0;
                            end
                        endcase
                    end
                end
            end
            OP_DISCONNECT: begin
                pause_next  = 1'b0;
                level_next  = LEVEL_SAFE;
                target_next = '0;
                light_next  = LIGHT_BLUE;
            end
            default: begin
            end
        endcase
    end

    assign result.coils          = coil_next;
    assign result.light_blue     = light_next[0];
    assign result.light_red      = light_next[1];
    assign result.motor_position = OUT_POS_BITS'(position_next);
    assign result.proximity      = level_next;
    assign result.paused         = pause_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg     <= STEP_PERIOD_RESET;
            blink_period_reg    <= BLINK_PERIOD_RESET;
            debounce_period_reg <= DEBOUNCE_PERIOD_RESET;
            approach_pos_reg    <= APPROACH_POS_RESET;
            close_pos_reg       <= CLOSE_POS_RESET;
        end else if (cfg_write_enable) begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_PERIOD:     step_period_reg     <= cfg_data;
                CFG_BLINK_PERIOD:    blink_period_reg    <= cfg_data;
                CFG_DEBOUNCE_PERIOD: debounce_period_reg <= cfg_data;
                CFG_APPROACH_POS:    approach_pos_reg    <= cfg_data[TARGET_BITS-1:0];
                CFG_CLOSE_POS:       close_pos_reg       <= cfg_data[TARGET_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg      <= '0;
            target_reg        <= '0;
            phase_reg         <= '0;
            level_reg         <= LEVEL_SAFE;
            pause_reg         <= 1'b0;
            blink_reg         <= 1'b0;
            coil_reg          <= '0;
            light_reg         <= LIGHT_BLUE;
            step_elapsed_reg  <= '0;
            blink_elapsed_reg <= '0;
            press_elapsed_reg <= '0;
        end else if (accept) begin
            position_reg      <= position_next;
            target_reg        <= target_next;
            phase_reg         <= phase_next;
            level_reg         <= level_next;
            pause_reg         <= pause_next;
            blink_reg         <= blink_next;
            coil_reg          <= coil_next;
            light_reg         <= light_next;
            step_elapsed_reg  <= step_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            press_elapsed_reg <= press_elapsed_next;
        end
    end

endmodule

>>> design/proximity_stepper_indicator_unit.sv
// Half-step stepper pointer and indicator light controller. Each input word
// (a microsecond tick with the button level, a proximity message, or a link
// disconnect) updates the motor, light, level, pause and timer state, and its
// status word is registered in the output buffer and shown on the m_ channel.
// One word is taken every cycle while s_ready is high; a two-word output
// buffer lets s_ready stay high for one more word while m_ready is low.
// Reset is synchronous, with no clearing pass. Write the configuration
// registers only while no word is in flight.
module proximity_stepper_indicator_unit
    import psi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int TIMER_BITS    = TIMER_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_write_enable,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [1:0]                s_message_state,
    input  logic                      s_button_low,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [3:0]                m_coils,
    output logic                      m_light_blue,
    output logic                      m_light_red,
    output logic [OUT_POS_BITS-1:0]   m_motor_position,
    output logic [1:0]                m_proximity,
    output logic                      m_paused
);

    logic    accept;
    result_t core_result;
    result_t out_word;

    assign accept = s_valid && s_ready;

    psi_core #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .accept           (accept),
        .op               (s_op),
        .message_state    (s_message_state),
        .button_low       (s_button_low),
        .result           (core_result)
    );

    psi_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_word)
    );

    assign m_coils          = out_word.coils;
    assign m_light_blue     = out_word.light_blue;
    assign m_light_red      = out_word.light_red;
    assign m_motor_position = out_word.motor_position;
    assign m_proximity      = out_word.proximity;
    assign m_paused         = out_word.paused;

endmodule

>>> tb/sv/tb_proximity_stepper_indicator_unit.sv
`timescale 1ns / 100ps

module tb_proximity_stepper_indicator_unit;
    import psi_pkg::*;

    localparam int TB = TIMER_BITS_DEFAULT;
    localparam int PB = POSITION_BITS_DEFAULT;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] LEVEL_UNUSED = 2'd3;
    localparam int LONG_STALL = 300;
    localparam logic [3:0] HALF_STEP [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] level;
        logic       button;
    } sensor_word_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_write_enable = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_op = '0;
    logic [1:0]                s_message_state = '0;
    logic                      s_button_low = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [3:0]                m_coils;
    logic                      m_light_blue;
    logic                      m_light_red;
    logic [OUT_POS_BITS-1:0]   m_motor_position;
    logic [1:0]                m_proximity;
    logic                      m_paused;

    proximity_stepper_indicator_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_message_state  (s_message_state),
        .s_button_low     (s_button_low),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coils          (m_coils),
        .m_light_blue     (m_light_blue),
        .m_light_red      (m_light_red),
        .m_motor_position (m_motor_position),
        .m_proximity      (m_proximity),
        .m_paused         (m_paused)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    logic [PERIOD_BITS-1:0] step_cfg, blink_cfg, debounce_cfg;
    logic [PB-1:0]          approach_cfg, close_cfg;

    logic [PB-1:0] motor_pos, motor_target;
    logic [2:0]    phase_idx;
    level_t        held_level;
    logic          pause_on, blink_on;
    logic [3:0]    coil_drive;
    logic [1:0]    lamp;
    logic [TB-1:0] step_ticks, blink_ticks, press_ticks;

    sensor_word_t pending_words[$];
    result_t      expected_status[$];
    sensor_word_t next_word;
    result_t      want;
    int           send_gap = 0;
    int           stall_left = 0;
    int           long_stall_count = 0;
    int           mismatches = 0;
    logic         idle_enable = 1'b1;
    logic         long_stall_req = 1'b0;

    function automatic void reset_indicator();
        step_cfg     = STEP_PERIOD_RESET;
        blink_cfg    = BLINK_PERIOD_RESET;
        debounce_cfg = DEBOUNCE_PERIOD_RESET;
        approach_cfg = APPROACH_POS_RESET;
        close_cfg    = CLOSE_POS_RESET;
        motor_pos    = '0;
        motor_target = '0;
        phase_idx    = '0;
        held_level   = LEVEL_SAFE;
        pause_on     = 1'b0;
        blink_on     = 1'b0;
        coil_drive   = '0;
        lamp         = LIGHT_BLUE;
        step_ticks   = '0;
        blink_ticks  = '0;
        press_ticks  = '0;
    endfunction

    function automatic logic [TB-1:0] sat_count(input logic [TB-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void follow_level();
        if (held_level == LEVEL_SAFE) lamp = LIGHT_BLUE;
        if (held_level == LEVEL_CLOSE) lamp = LIGHT_RED;
        motor_target = (held_level == LEVEL_APPROACH) ? approach_cfg :
                       (held_level == LEVEL_CLOSE) ? close_cfg : '0;
    endfunction

    function automatic result_t advance_indicator(input logic [1:0] op, input logic [1:0] level,
                                                  input logic button);
        result_t status;
        logic    up;
        case (op)
            OP_TICK: begin
                step_ticks  = sat_count(step_ticks);
                blink_ticks = sat_count(blink_ticks);
                press_ticks = sat_count(press_ticks);
                if (step_ticks >= step_cfg) begin
                    step_ticks = '0;
                    if (motor_pos != motor_target) begin
                        up = motor_target > motor_pos;
                        phase_idx = up ? phase_idx - 3'd1 : phase_idx + 3'd1;
                        coil_drive = HALF_STEP[phase_idx];
                        motor_pos = up ? motor_pos + 1'b1 : motor_pos - 1'b1;
                        if (motor_pos == motor_target) coil_drive = '0;
                    end
                end
                if (held_level == LEVEL_APPROACH && !pause_on && blink_ticks >= blink_cfg) begin
                    blink_ticks = '0;
                    blink_on = !blink_on;
                    lamp = blink_on ? LIGHT_RED : LIGHT_DARK;
                end
                if (button && press_ticks > debounce_cfg) begin
                    press_ticks = '0;
                    pause_on = !pause_on;
                    if (pause_on) begin
                        lamp = LIGHT_BLUE;
                        motor_target = '0;
                    end else begin
                        follow_level();
                    end
                end
            end
            OP_MESSAGE: begin
                if (level != LEVEL_UNUSED) begin
                    if (pause_on) begin
                        held_level = level_t'(level);
                    end else if (level != held_level) begin
                        held_level = level_t'(level);
                        follow_level();
                    end
                end
            end
            OP_DISCONNECT: begin
                pause_on = 1'b0;
                held_level = LEVEL_SAFE;
                motor_target = '0;
                lamp = LIGHT_BLUE;
            end
            default: ;
        endcase
        status.coils          = coil_drive;
        status.light_blue     = lamp[0];
        status.light_red      = lamp[1];
        status.motor_position = motor_pos;
        status.proximity      = held_level;
        status.paused         = pause_on;
        return status;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_status.push_back(advance_indicator(s_op, s_message_state, s_button_low));
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_op <= next_word.op;
                    s_message_state <= next_word.level;
                    s_button_low <= next_word.button;
                    if (idle_enable && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [11:0] want_v, got_v);
        if (want_v !== got_v) begin
            $error("%s expected %0d got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $error("status word arrived with none expected");
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("coils", want.coils, m_coils);
                    check_field("light_blue", want.light_blue, m_light_blue);
                    check_field("light_red", want.light_red, m_light_red);
                    check_field("motor_position", want.motor_position, m_motor_position);
                    check_field("proximity", want.proximity, m_proximity);
                    check_field("paused", want.paused, m_paused);
                end
            end
            if (long_stall_req && long_stall_count < LONG_STALL) begin
                m_ready <= 1'b0;
                long_stall_count <= long_stall_count + 1;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 19);
            end
        end
    end

    function automatic void queue_word(input logic [1:0] op, input logic [1:0] level,
                                       input logic button);
        sensor_word_t w;
        w.op = op;
        w.level = level;
        w.button = button;
        pending_words.push_back(w);
    endfunction

    task automatic drain();
        while (pending_words.size() != 0 || s_valid || expected_status.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_STEP_PERIOD:     step_cfg = value;
            CFG_BLINK_PERIOD:    blink_cfg = value;
            CFG_DEBOUNCE_PERIOD: debounce_cfg = value;
            CFG_APPROACH_POS:    approach_cfg = value[PB-1:0];
            CFG_CLOSE_POS:       close_cfg = value[PB-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_BITS-1:0] step_p, blink_p, debounce_p,
                              approach_p, close_p);
        write_reg(CFG_STEP_PERIOD, step_p);
        write_reg(CFG_BLINK_PERIOD, blink_p);
        write_reg(CFG_DEBOUNCE_PERIOD, debounce_p);
        write_reg(CFG_APPROACH_POS, approach_p);
        write_reg(CFG_CLOSE_POS, close_p);
    endtask

    task automatic set_random_config();
        set_config($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 12),
                   $urandom_range(0, 40), $urandom_range(0, 40));
    endtask

    task automatic run_random(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                queue_word(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 1));
            else if (pick < 4)
                queue_word(OP_MESSAGE, LEVEL_UNUSED, $urandom_range(0, 1));
            else if (pick < 6)
                queue_word(OP_DISCONNECT, $urandom_range(0, 3), $urandom_range(0, 1));
            else if (pick < 18)
                queue_word(OP_MESSAGE, $urandom_range(0, 2), $urandom_range(0, 1));
            else
                queue_word(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 5) == 0);
        end
        drain();
    endtask

    initial begin
        reset_indicator();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        queue_word(OP_TICK, LEVEL_SAFE, 1'b0);
        queue_word(OP_TICK, LEVEL_SAFE, 1'b1);
        queue_word(OP_MESSAGE, LEVEL_CLOSE, 1'b0);
        queue_word(OP_MESSAGE, LEVEL_CLOSE, 1'b0);
        queue_word(OP_MESSAGE, LEVEL_UNUSED, 1'b0);
        queue_word(OP_UNUSED, LEVEL_APPROACH, 1'b1);
        queue_word(OP_DISCONNECT, LEVEL_CLOSE, 1'b1);
        drain();

        set_config(0, 1, 0, 3, 6);
        queue_word(OP_MESSAGE, LEVEL_APPROACH, 1'b0);
        repeat (4) queue_word(OP_TICK, LEVEL_SAFE, 1'b0);
        queue_word(OP_TICK, LEVEL_SAFE, 1'b1);
        queue_word(OP_MESSAGE, LEVEL_CLOSE, 1'b0);
        repeat (2) queue_word(OP_TICK, LEVEL_SAFE, 1'b0);
        queue_word(OP_TICK, LEVEL_SAFE, 1'b1);
        repeat (3) queue_word(OP_TICK, LEVEL_SAFE, 1'b0);
        queue_word(OP_DISCONNECT, LEVEL_SAFE, 1'b0);
        repeat (2) queue_word(OP_TICK, LEVEL_SAFE, 1'b0);
        drain();

        set_config(1, 2, 3, 5, 9);
        run_random(150);
        set_config(0, 0, 0, 0, 4095);
        run_random(150);
        set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4095, 0);
        run_random(80);
        set_random_config();
        long_stall_req <= 1'b1;
        run_random(150);
        set_random_config();
        run_random(150);
        idle_enable <= 1'b0;
        set_random_config();
        run_random(100);

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("PASS proximity_stepper_indicator_unit");
        end else begin
            $display("FAIL proximity_stepper_indicator_unit");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL proximity_stepper_indicator_unit");
        $finish;
    end

endmodule
